### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared widths, result codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Field widths of the item and the configuration register.
    localparam int BS_W      = 13;
    localparam int OFF_W     = 20;
    localparam int ST_W      = 2;
    localparam int OUT_ORD_W = 3;

    // Divider iteration counter covers one step per offset bit.
    localparam int DCNT_W    = $clog2(OFF_W);

    // Reset value of the block size register.
    localparam logic [BS_W-1:0] BS_RESET = BS_W'(16);

    // Action codes.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FAIL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_A_SIZE,
        S_A_FIND,
        S_A_SPLIT,
        S_F_DIV,
        S_F_LOOK,
        S_F_CHECK,
        S_F_MERGE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture an accepted item
        logic size_inc;    // try the next order for the request size
        logic size_done;   // request order settled, start the free search there
        logic find_inc;    // search the next larger order
        logic take;        // take the lowest free block of the current order
        logic split;       // free the upper half one level down
        logic alloc_ok;    // record the allocation and form the result
        logic div_step;    // one step of the offset division
        logic read_order;  // latch the block index and read its order
        logic free_start;  // release the block and start merging
        logic merge;       // merge with the free buddy and climb one order
        logic merge_end;   // mark the merged block free and form the result
        logic fail_alloc;  // result: allocation failed
        logic fail_free;   // result: free rejected
        logic out_load;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;     // captured item is a free
        logic too_big;     // request exceeds the whole pool
        logic size_fit;    // current order covers the request
        logic ord_last;    // request order is the top order
        logic row_any;     // current order has a free block
        logic lvl_last;    // search order is the top order
        logic split_done;  // split has come down to the request order
        logic div_last;    // this division step is the final one
        logic off_bad;     // offset misaligned, beyond pool, or block size zero
        logic not_used;    // block at the offset is not allocated
        logic merge_stop;  // buddy unavailable or top order reached
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

### src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// State machine that sequences size search, free search, splitting, offset
// division and merging by issuing commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd      o_cmd
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Items are taken only between operations.
    assign o_in_stall = (r_state != bba_pkg::S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bba_pkg::S_A_SIZE;
                end
            end
            bba_pkg::S_A_SIZE: begin
                if (i_sts.is_free) begin
                    n_state = bba_pkg::S_F_DIV;
                end else if (i_sts.too_big) begin
                    o_cmd.fail_alloc = 1'b1;
                    n_state          = bba_pkg::S_DONE;
                end else if (i_sts.size_fit) begin
                    o_cmd.size_done = 1'b1;
                    n_state         = bba_pkg::S_A_FIND;
                end else if (i_sts.ord_last) begin
                    o_cmd.fail_alloc = 1'b1;
                    n_state          = bba_pkg::S_DONE;
                end else begin
                    o_cmd.size_inc = 1'b1;
                end
            end
            bba_pkg::S_A_FIND: begin
                if (i_sts.row_any) begin
                    o_cmd.take = 1'b1;
                    n_state    = bba_pkg::S_A_SPLIT;
                end else if (i_sts.lvl_last) begin
                    o_cmd.fail_alloc = 1'b1;
                    n_state          = bba_pkg::S_DONE;
                end else begin
                    o_cmd.find_inc = 1'b1;
                end
            end
            bba_pkg::S_A_SPLIT: begin
                if (i_sts.split_done) begin
                    o_cmd.alloc_ok = 1'b1;
                    n_state        = bba_pkg::S_DONE;
                end else begin
                    o_cmd.split = 1'b1;
                end
            end
            bba_pkg::S_F_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = bba_pkg::S_F_LOOK;
                end
            end
            bba_pkg::S_F_LOOK: begin
                if (i_sts.off_bad) begin
                    o_cmd.fail_free = 1'b1;
                    n_state         = bba_pkg::S_DONE;
                end else begin
                    o_cmd.read_order = 1'b1;
                    n_state          = bba_pkg::S_F_CHECK;
                end
            end
            bba_pkg::S_F_CHECK: begin
                if (i_sts.not_used) begin
                    o_cmd.fail_free = 1'b1;
                    n_state         = bba_pkg::S_DONE;
                end else begin
                    o_cmd.free_start = 1'b1;
                    n_state          = bba_pkg::S_F_MERGE;
                end
            end
            bba_pkg::S_F_MERGE: begin
                if (i_sts.merge_stop) begin
                    o_cmd.merge_end = 1'b1;
                    n_state         = bba_pkg::S_DONE;
                end else begin
                    o_cmd.merge = 1'b1;
                end
            end
            bba_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/bba_dp.sv
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Free bitmaps per order, allocation flags, the order memory, the offset
// divider and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
    parameter int NUM_BLOCKS = 64,
    parameter int NUM_ORDERS = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bba_pkg::BS_W-1:0]      i_cfg_wdata,
    input  wire logic                          i_action,
    input  wire logic [bba_pkg::OFF_W-1:0]     i_request_bytes,
    input  wire logic [bba_pkg::OFF_W-1:0]     i_free_offset,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [bba_pkg::ST_W-1:0]           o_status,
    output logic [bba_pkg::OFF_W-1:0]          o_alloc_offset,
    output logic [bba_pkg::OUT_ORD_W-1:0]      o_alloc_order,
    input  wire bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_sts                      o_sts
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int ORD_W  = $clog2(NUM_ORDERS);
    localparam int PW     = bba_pkg::BS_W + IDX_W + 1;
    localparam int SH_W   = bba_pkg::BS_W + NUM_ORDERS;
    // Compare width wide enough for request, pool size and shifted size.
    localparam int CW0    = (PW > SH_W) ? PW : SH_W;
    localparam int CW     = (CW0 > bba_pkg::OFF_W) ? CW0 : bba_pkg::OFF_W;
    // Index arithmetic width wide enough for any order span.
    localparam int XW0    = (IDX_W > NUM_ORDERS) ? IDX_W : NUM_ORDERS;
    localparam int XW     = XW0 + 2;
    localparam int RW     = bba_pkg::BS_W + 1;
    localparam int PRD_W  = IDX_W + bba_pkg::BS_W;

    localparam logic [PW-1:0]       NB_P      = PW'(NUM_BLOCKS);
    localparam logic [XW-1:0]       NB_X      = XW'(NUM_BLOCKS);
    localparam logic [ORD_W-1:0]    ORD_TOP   = ORD_W'(NUM_ORDERS - 1);
    localparam logic [ORD_W:0]      ORD_NUM   = (ORD_W + 1)'(NUM_ORDERS);
    localparam logic [bba_pkg::DCNT_W-1:0] DCNT_LAST = bba_pkg::DCNT_W'(bba_pkg::OFF_W - 1);

    // Greedy cover of the pool with the largest aligned blocks that fit.
    function automatic logic [NUM_ORDERS-1:0][NUM_BLOCKS-1:0] init_map();
        logic [NUM_ORDERS-1:0][NUM_BLOCKS-1:0] m;
        int pos;
        int o;
        m   = '0;
        pos = 0;
        for (int s = 0; s < NUM_BLOCKS; s++) begin
            if (pos < NUM_BLOCKS) begin
                o = NUM_ORDERS - 1;
                for (int k = 0; k < NUM_ORDERS; k++) begin
                    if (o > 0 && ((pos & ((1 << o) - 1)) != 0 || pos + (1 << o) > NUM_BLOCKS)) begin
                        o = o - 1;
                    end
                end
                m[o][pos] = 1'b1;
                pos       = pos + (1 << o);
            end
        end
        return m;
    endfunction

    localparam logic [NUM_ORDERS-1:0][NUM_BLOCKS-1:0] FREE_INIT = init_map();

    // Configuration and state.
    logic [bba_pkg::BS_W-1:0]              r_block_size;
    logic [PW-1:0]                         r_pool;
    logic [NUM_ORDERS-1:0][NUM_BLOCKS-1:0] r_free_map;
    logic [NUM_BLOCKS-1:0]                 r_used;
    logic [ORD_W-1:0]                      r_order_mem [NUM_BLOCKS];

    // Working registers.
    logic                          r_action;
    logic [bba_pkg::OFF_W-1:0]     r_req;
    logic [ORD_W-1:0]              r_ord;
    logic [ORD_W-1:0]              r_lvl;
    logic [IDX_W-1:0]              r_pos;
    logic [IDX_W-1:0]              r_idx;
    logic [ORD_W-1:0]              r_ord_rd;
    logic [RW-1:0]                 r_rem;
    logic [bba_pkg::OFF_W-1:0]     r_quo;
    logic [bba_pkg::DCNT_W-1:0]    r_dcnt;

    // Result and output registers.
    logic [bba_pkg::ST_W-1:0]      r_res_status;
    logic [bba_pkg::OFF_W-1:0]     r_res_offset;
    logic [ORD_W-1:0]              r_res_order;
    logic                          r_out_valid;
    logic [bba_pkg::ST_W-1:0]      r_out_status;
    logic [bba_pkg::OFF_W-1:0]     r_out_offset;
    logic [bba_pkg::OUT_ORD_W-1:0] r_out_order;

    // Combinational helpers.
    logic [NUM_BLOCKS-1:0]     row;
    logic [IDX_W-1:0]          low_idx;
    logic [CW-1:0]             bs_shift;
    logic [XW-1:0]             span;
    logic [XW-1:0]             half_span;
    logic [XW-1:0]             half_x;
    logic [XW-1:0]             buddy_x;
    logic [IDX_W-1:0]          half_i;
    logic [IDX_W-1:0]          buddy_i;
    logic [RW-1:0]             rem_sh;
    logic [RW-1:0]             rem_diff;
    logic                      q_bit;
    logic [PRD_W-1:0]          prod;
    logic [ORD_W-1:0]          lvl_dn;

    // Row of the current search order and its lowest free block.
    assign row = r_free_map[r_lvl];
    always_comb begin
        low_idx = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            if (row[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    // Byte span of the candidate order.
    assign bs_shift = CW'(r_block_size) << r_ord;

    // Upper half on a split and buddy on a merge.
    assign lvl_dn    = r_lvl - ORD_W'(1);
    assign span      = XW'(1) << r_lvl;
    assign half_span = XW'(1) << lvl_dn;
    assign half_x    = XW'(r_pos) + half_span;
    assign buddy_x   = XW'(r_idx) ^ span;
    assign half_i    = half_x[IDX_W-1:0];
    assign buddy_i   = buddy_x[IDX_W-1:0];

    // One restoring division step.
    assign rem_sh   = {r_rem[RW-2:0], r_quo[bba_pkg::OFF_W-1]};
    assign rem_diff = rem_sh - RW'(r_block_size);
    assign q_bit    = (rem_sh >= RW'(r_block_size));

    // Byte offset of the allocated block.
    assign prod = PRD_W'(r_pos) * PRD_W'(r_block_size);

    // Status towards the controller.
    always_comb begin
        o_sts            = '0;
        o_sts.is_free    = (r_action == bba_pkg::ACT_FREE);
        o_sts.too_big    = (CW'(r_req) > CW'(r_pool));
        o_sts.size_fit   = (bs_shift >= CW'(r_req));
        o_sts.ord_last   = (r_ord == ORD_TOP);
        o_sts.row_any    = |row;
        o_sts.lvl_last   = (r_lvl == ORD_TOP);
        o_sts.split_done = (r_lvl == r_ord);
        o_sts.div_last   = (r_dcnt == DCNT_LAST);
        o_sts.off_bad    = (r_block_size == '0) || (r_rem != '0)
                           || ((bba_pkg::OFF_W + 1)'(r_quo) >= (bba_pkg::OFF_W + 1)'(NUM_BLOCKS));
        o_sts.not_used   = !r_used[r_idx] || ({1'b0, r_ord_rd} >= ORD_NUM);
        o_sts.merge_stop = (r_lvl == ORD_TOP) || (buddy_x + span > NB_X)
                           || !r_free_map[r_lvl][buddy_i];
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // Block size register and pool size derived from it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= bba_pkg::BS_RESET;
            r_pool       <= NB_P * PW'(bba_pkg::BS_RESET);
        end else if (i_cfg_we) begin
            r_block_size <= i_cfg_wdata;
            r_pool       <= NB_P * PW'(i_cfg_wdata);
        end
    end

    // Free bitmaps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= FREE_INIT;
        end else if (i_cmd.take) begin
            r_free_map[r_lvl][low_idx] <= 1'b0;
        end else if (i_cmd.split) begin
            if (half_x < NB_X) begin
                r_free_map[lvl_dn][half_i] <= 1'b1;
            end
        end else if (i_cmd.merge) begin
            r_free_map[r_lvl][buddy_i] <= 1'b0;
        end else if (i_cmd.merge_end) begin
            r_free_map[r_lvl][r_idx] <= 1'b1;
        end
    end

    // Allocation flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.alloc_ok) begin
            r_used[r_pos] <= 1'b1;
        end else if (i_cmd.free_start) begin
            r_used[r_idx] <= 1'b0;
        end
    end

    // Order memory: written on allocation, read when freeing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_ok) begin
            r_order_mem[r_pos] <= r_ord;
        end
        if (i_cmd.read_order) begin
            r_ord_rd <= r_order_mem[r_quo[IDX_W-1:0]];
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_req    <= i_request_bytes;
            r_ord    <= '0;
            r_quo    <= i_free_offset;
            r_rem    <= '0;
            r_dcnt   <= '0;
        end
        if (i_cmd.size_inc) begin
            r_ord <= r_ord + ORD_W'(1);
        end
        if (i_cmd.size_done) begin
            r_lvl <= r_ord;
        end
        if (i_cmd.find_inc) begin
            r_lvl <= r_lvl + ORD_W'(1);
        end
        if (i_cmd.take) begin
            r_pos <= low_idx;
        end
        if (i_cmd.split) begin
            r_lvl <= lvl_dn;
        end
        if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_diff : rem_sh;
            r_quo  <= {r_quo[bba_pkg::OFF_W-2:0], q_bit};
            r_dcnt <= r_dcnt + bba_pkg::DCNT_W'(1);
        end
        if (i_cmd.read_order) begin
            r_idx <= r_quo[IDX_W-1:0];
        end
        if (i_cmd.free_start) begin
            r_lvl <= r_ord_rd;
            r_ord <= r_ord_rd;
        end
        if (i_cmd.merge) begin
            r_lvl <= r_lvl + ORD_W'(1);
            if (buddy_i < r_idx) begin
                r_idx <= buddy_i;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_ok) begin
            r_res_status <= bba_pkg::ST_OK;
            r_res_offset <= bba_pkg::OFF_W'(prod);
            r_res_order  <= r_ord;
        end else if (i_cmd.merge_end) begin
            r_res_status <= bba_pkg::ST_OK;
            r_res_offset <= '0;
            r_res_order  <= r_ord;
        end else if (i_cmd.fail_alloc) begin
            r_res_status <= bba_pkg::ST_FAIL;
            r_res_offset <= '0;
            r_res_order  <= '0;
        end else if (i_cmd.fail_free) begin
            r_res_status <= bba_pkg::ST_BAD;
            r_res_offset <= '0;
            r_res_order  <= '0;
        end
    end

    // Output register, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_offset <= r_res_offset;
            r_out_order  <= bba_pkg::OUT_ORD_W'(r_res_order);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_alloc_offset = r_out_offset;
    assign o_alloc_order  = r_out_order;

endmodule

`default_nettype wire

### src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over NUM_BLOCKS base blocks with NUM_ORDERS orders.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one item: an
// action, a request size in bytes and an offset to free. Each item gives
// exactly one result item on the output channel (o_out_valid / i_out_stall):
// a status, the byte offset of an allocated block and its order.
// The block size register is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. It resets to 16 bytes. An allocation sizes the request
// order by order, searches the orders upward for a free block and splits
// down to the request order, each at most NUM_ORDERS steps. A free runs a
// bit-serial offset division, one step per offset bit, then checks the
// block and merges level by level. One item is in work at a time; the next
// is accepted once the result has moved into the output register.
// After reset the whole pool is free, covered by the largest aligned blocks.
// A stalled result holds in the output register; the block accepts the next
// item meanwhile and waits only to hand over its following result.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator #(
    parameter int NUM_BLOCKS = 64,
    parameter int NUM_ORDERS = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bba_pkg::BS_W-1:0]      i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [bba_pkg::OFF_W-1:0]     i_request_bytes,
    input  wire logic [bba_pkg::OFF_W-1:0]     i_free_offset,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [bba_pkg::ST_W-1:0]           o_status,
    output logic [bba_pkg::OFF_W-1:0]          o_alloc_offset,
    output logic [bba_pkg::OUT_ORD_W-1:0]      o_alloc_order
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    // Sequencer.
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Bitmaps, divider and result path.
    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_ORDERS (NUM_ORDERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_alloc_offset  (o_alloc_offset),
        .o_alloc_order   (o_alloc_order),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

`default_nettype wire

### sim/bba_checker.sv
// ----------------------------------------------------------------------------
// Buddy allocator result checker
// Watches both channels of the allocator and the block size register, keeps
// its own copy of the free maps and the allocated-block records, and checks
// every result item field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module bba_checker #(
    parameter int NUM_BLOCKS = 64,
    parameter int NUM_ORDERS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::BS_W-1:0]      i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_action,
    input  logic [bba_pkg::OFF_W-1:0]     i_request_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     i_free_offset,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [bba_pkg::ST_W-1:0]      i_status,
    input  logic [bba_pkg::OFF_W-1:0]     i_alloc_offset,
    input  logic [bba_pkg::OUT_ORD_W-1:0] i_alloc_order,
    output int                            o_errors,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bba_pkg::ST_W-1:0]      status;
        logic [bba_pkg::OFF_W-1:0]     offset;
        logic [bba_pkg::OUT_ORD_W-1:0] order;
    } t_result;

    logic [bba_pkg::BS_W-1:0] blk_bytes;
    logic                     free_bits [NUM_ORDERS][NUM_BLOCKS];
    logic                     in_use [NUM_BLOCKS];
    int                       held_order [NUM_BLOCKS];
    t_result                  expected_results [$];

    // Cover the pool greedily with the largest aligned free blocks.
    task automatic clear_pool();
        int pos;
        int o;
        pos = 0;
        for (int k = 0; k < NUM_ORDERS; k++)
            for (int b = 0; b < NUM_BLOCKS; b++) free_bits[k][b] = 1'b0;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            in_use[b] = 1'b0;
            held_order[b] = 0;
        end
        while (pos < NUM_BLOCKS) begin
            o = NUM_ORDERS - 1;
            while (o > 0 && ((pos % (1 << o)) != 0 || pos + (1 << o) > NUM_BLOCKS)) o--;
            free_bits[o][pos] = 1'b1;
            pos += 1 << o;
        end
    endtask

    // Allocation: size the request, find the lowest free block, split down.
    function automatic t_result allocate(logic [bba_pkg::OFF_W-1:0] req);
        t_result r;
        longint  bs;
        int      want;
        int      lvl;
        int      pos;
        bit      found;
        r = '{status: bba_pkg::ST_FAIL, offset: '0, order: '0};
        bs = blk_bytes;
        want = 0;
        found = 0;
        pos = 0;
        if (longint'(req) > NUM_BLOCKS * bs) return r;
        while (want < NUM_ORDERS && (bs << want) < req) want++;
        if (want >= NUM_ORDERS) return r;
        for (lvl = want; lvl < NUM_ORDERS && !found; lvl++) begin
            for (int b = 0; b < NUM_BLOCKS; b++)
                if (free_bits[lvl][b]) begin
                    pos = b;
                    found = 1;
                    break;
                end
            if (found) break;
        end
        if (!found) return r;
        free_bits[lvl][pos] = 1'b0;
        for (int l = lvl; l > want; l--)
            if (pos + (1 << (l - 1)) < NUM_BLOCKS) free_bits[l - 1][pos + (1 << (l - 1))] = 1'b1;
        in_use[pos] = 1'b1;
        held_order[pos] = want;
        r.status = bba_pkg::ST_OK;
        r.offset = bba_pkg::OFF_W'(longint'(pos) * bs);
        r.order = bba_pkg::OUT_ORD_W'(want);
        return r;
    endfunction

    // Release: validate the offset, then merge while the buddy is free.
    function automatic t_result release_block(logic [bba_pkg::OFF_W-1:0] off);
        t_result r;
        int      idx;
        int      ord;
        int      buddy;
        r = '{status: bba_pkg::ST_BAD, offset: '0, order: '0};
        if (blk_bytes == 0 || off % blk_bytes != 0 || off / blk_bytes >= NUM_BLOCKS) return r;
        idx = off / blk_bytes;
        if (!in_use[idx]) return r;
        ord = held_order[idx];
        r.status = bba_pkg::ST_OK;
        r.order = bba_pkg::OUT_ORD_W'(ord);
        in_use[idx] = 1'b0;
        while (ord + 1 < NUM_ORDERS) begin
            buddy = idx ^ (1 << ord);
            if (buddy + (1 << ord) > NUM_BLOCKS || !free_bits[ord][buddy]) break;
            free_bits[ord][buddy] = 1'b0;
            if (buddy < idx) idx = buddy;
            ord++;
        end
        free_bits[ord][idx] = 1'b1;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    // Predict on accepted items and compare accepted results.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            blk_bytes <= bba_pkg::BS_RESET;
            clear_pool();
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) blk_bytes <= i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_action == bba_pkg::ACT_ALLOC)
                    expected_results.push_back(allocate(i_request_bytes));
                else expected_results.push_back(release_block(i_free_offset));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{status: i_status, offset: i_alloc_offset, order: i_alloc_order};
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.status !== exp_r.status)
                        $error("status expected %0d got %0d", exp_r.status, got.status);
                    if (got.offset !== exp_r.offset)
                        $error("alloc_offset expected %0d got %0d", exp_r.offset, got.offset);
                    if (got.order !== exp_r.order)
                        $error("alloc_order expected %0d got %0d", exp_r.order, got.order);
                    if (got !== exp_r) o_errors <= o_errors + 1;
                end
            end
        end
    end
endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Buddy allocator testbench
// Drives directed and random allocate and free items through the allocator
// under several block sizes, with random idling on both channels, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS = 64;
    localparam int WATCH_LIMIT = 20000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [bba_pkg::BS_W-1:0]          cfg_wdata = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              action = bba_pkg::ACT_ALLOC;
    logic [bba_pkg::OFF_W-1:0]         request_bytes = '0;
    logic [bba_pkg::OFF_W-1:0]         free_offset = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [bba_pkg::ST_W-1:0]          status;
    logic [bba_pkg::OFF_W-1:0]         alloc_offset;
    logic [bba_pkg::OUT_ORD_W-1:0]     alloc_order;
    int                                errors;
    int                                pending;
    bit                                calm = 0;
    int                                idle_cycles = 0;
    logic [bba_pkg::OFF_W-1:0]         live_offsets [$];
    logic                              live_tag [$];
    logic [bba_pkg::BS_W-1:0]          cur_bs = bba_pkg::BS_RESET;

    always #6 clk = ~clk;

    buddy_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_action(action),
        .i_request_bytes(request_bytes), .i_free_offset(free_offset),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_status(status),
        .o_alloc_offset(alloc_offset), .o_alloc_order(alloc_order)
    );

    bba_checker #(.NUM_BLOCKS(NUM_BLOCKS)) chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_action(action),
        .i_request_bytes(request_bytes), .i_free_offset(free_offset),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_alloc_offset(alloc_offset), .i_alloc_order(alloc_order),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver stalls in random bursts until the calm tail of the run.
    always @(posedge clk) begin
        int burst;
        if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 11);
            out_stall <= 1'b1;
            repeat (burst) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one item and hold it until accepted; drop valid for a cycle after.
    task automatic send(logic act, logic [bba_pkg::OFF_W-1:0] req,
                        logic [bba_pkg::OFF_W-1:0] off);
        if (!calm && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 11)) @(posedge clk);
        in_valid <= 1'b1;
        action <= act;
        request_bytes <= req;
        free_offset <= off;
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic alloc_item(logic [bba_pkg::OFF_W-1:0] req);
        send(bba_pkg::ACT_ALLOC, req, bba_pkg::OFF_W'($urandom));
    endtask

    // Free the block at the given offset, often one taken from the harvested offsets.
    task automatic free_item(logic [bba_pkg::OFF_W-1:0] off);
        send(bba_pkg::ACT_FREE, bba_pkg::OFF_W'($urandom), off);
    endtask

    // Harvest successful allocation offsets so frees can target real blocks.
    always @(posedge clk)
        if (out_valid && !out_stall && status == bba_pkg::ST_OK && live_tag.size() > 0) begin
            if (live_tag.pop_front() == bba_pkg::ACT_ALLOC) live_offsets.push_back(alloc_offset);
        end
    always @(posedge clk)
        if (in_valid && !in_stall) live_tag.push_back(action);
    // Drop tags of results that were not ok so the tag queue stays aligned.
    always @(posedge clk)
        if (out_valid && !out_stall && status != bba_pkg::ST_OK && live_tag.size() > 0)
            void'(live_tag.pop_front());

    // Wait for every expected result to come out.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_block_size(logic [bba_pkg::BS_W-1:0] bs);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= bs;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_bs = bs;
        live_offsets.delete();
    endtask

    // Random phase: mostly allocations and frees of held blocks, some noise.
    task automatic random_phase(int count);
        int pick;
        int idx;
        logic [bba_pkg::OFF_W-1:0] bytes;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                bytes = (cur_bs == 0) ? bba_pkg::OFF_W'($urandom_range(0, 3)) :
                        bba_pkg::OFF_W'($urandom_range(0, 64 * cur_bs));
                if ($urandom_range(0, 3) == 0)
                    bytes = bba_pkg::OFF_W'($urandom_range(0, 2 * cur_bs + 1));
                alloc_item(bytes);
            end else if (pick < 85 && live_offsets.size() > 0) begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                free_item(live_offsets[idx]);
                live_offsets.delete(idx);
            end else if (pick < 93) begin
                free_item(bba_pkg::OFF_W'(cur_bs * $urandom_range(0, 70)));
            end else begin
                send(1'($urandom_range(0, 1)), bba_pkg::OFF_W'($urandom),
                     bba_pkg::OFF_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero request, extremes, split and merge, bad frees.
        alloc_item('0);
        alloc_item(bba_pkg::OFF_W'(1));
        alloc_item(bba_pkg::OFF_W'(17));
        alloc_item(bba_pkg::OFF_W'(100));
        alloc_item('1);
        alloc_item(bba_pkg::OFF_W'(1024));
        free_item('0);
        free_item('0);
        free_item(bba_pkg::OFF_W'(8));
        free_item(bba_pkg::OFF_W'(16 * 64));
        free_item('1);
        free_item(bba_pkg::OFF_W'(16));
        free_item(bba_pkg::OFF_W'(32));
        free_item(bba_pkg::OFF_W'(64));
        alloc_item(bba_pkg::OFF_W'(1024));
        alloc_item(bba_pkg::OFF_W'(1));
        free_item('0);
        send(bba_pkg::ACT_FREE, '1, '0);
        send(bba_pkg::ACT_ALLOC, '0, '1);

        set_block_size('0);
        alloc_item('0);
        alloc_item(bba_pkg::OFF_W'(1));
        free_item('0);
        set_block_size(bba_pkg::BS_W'(4096));
        alloc_item('1);
        alloc_item(bba_pkg::OFF_W'(4096 * 64));
        random_phase(80);
        set_block_size(bba_pkg::BS_W'(1));
        random_phase(170);
        set_block_size(bba_pkg::BS_W'(16));
        random_phase(170);
        set_block_size(bba_pkg::BS_W'($urandom_range(2, 4095)));
        random_phase(170);
        set_block_size(bba_pkg::BS_W'(3));
        calm = 1;
        random_phase(140);
        drain();
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
